/* hdl/qvr_pkg.sv */
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths and beat types for the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int VEC_WIDTH      = 16;  // vector and result component width
  localparam int QUAT_WIDTH     = 16;  // quaternion component width
  localparam int QUAT_FRAC_BITS = 14;  // default Q1.F fraction bits

  // one input beat: quaternion q and vector v
  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;
  } qvr_in_t;

  // one result beat: rotated vector and clamp flag
  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] out_x;
    logic signed [VEC_WIDTH-1:0] out_y;
    logic signed [VEC_WIDTH-1:0] out_z;
    logic                        saturated;
  } qvr_out_t;

endpackage

/* hdl/quaternion_vector_rotate.sv */
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a vector v by a quaternion q, returning the vector part of
// conj(q) * (v, 0) * q. The arithmetic is exact: the sum carries twice the
// quaternion fraction bits, is rounded half up to an integer and clamped to
// the signed vector width, with saturated set if any component was clamped.
// q is not normalised, so a non-unit q also scales v by |q|^2. One beat is
// taken every cycle while item_stall is low, and each result passes through
// the five register stages (product, sum, product, round, clamp). Each stage
// holds only while its successor is full and stalled, so bubbles are
// squeezed out and item_stall rises only once the whole pipe is full and
// the result side is stalling.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS
) (
  input  logic            clk,
  input  logic            rst,
  // input channel
  input  logic            item_valid,
  output logic            item_stall,
  input  qvr_pkg::qvr_in_t  item_data,
  // result channel
  output logic            result_valid,
  input  logic            result_stall,
  output qvr_pkg::qvr_out_t result_data
);

  localparam int QW    = qvr_pkg::QUAT_WIDTH;
  localparam int VW    = qvr_pkg::VEC_WIDTH;
  localparam int MW    = QW + VW;            // first product width
  localparam int PW    = MW + 2;             // p = conj(q) * v component width
  localparam int NW    = QW + PW;            // second product width
  localparam int SW    = NW + 2;             // sum of four products
  localparam int SHIFT = 2 * QUAT_FRAC_BITS;
  // room for the sum plus the rounding bias
  localparam int AW    = (SW + 1 > SHIFT + 1) ? SW + 1 : SHIFT + 1;

  localparam logic signed [AW-1:0] BIAS =
    {{(AW-SHIFT){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};
  localparam logic signed [AW-1:0] TOP  = {{(AW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [AW-1:0] BOT  = {{(AW-VW+1){1'b1}}, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] TOPV = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] BOTV = {1'b1, {(VW-1){1'b0}}};

  // stage enables: a stage loads when empty or when its successor moves on
  logic a_en, b_en, c_en, d_en, e_en;
  logic a_valid, b_valid, c_valid, d_valid;

  assign e_en = !result_valid || !result_stall;
  assign d_en = !d_valid || e_en;
  assign c_en = !c_valid || d_en;
  assign b_en = !b_valid || c_en;
  assign a_en = !a_valid || b_en;
  assign item_stall = !a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      d_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (a_en) a_valid      <= item_valid;
      if (b_en) b_valid      <= a_valid;
      if (c_en) c_valid      <= b_valid;
      if (d_en) d_valid      <= c_valid;
      if (e_en) result_valid <= d_valid;
    end
  end

  // stage A: the twelve products of conj(q) * (v, 0)
  logic signed [QW-1:0] a_ux, a_uy, a_uz, a_w;
  logic signed [MW-1:0] a_wvx, a_uyvz, a_uzvy;
  logic signed [MW-1:0] a_wvy, a_uzvx, a_uxvz;
  logic signed [MW-1:0] a_wvz, a_uxvy, a_uyvx;
  logic signed [MW-1:0] a_uxvx, a_uyvy, a_uzvz;

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_ux   <= item_data.quat_x;
      a_uy   <= item_data.quat_y;
      a_uz   <= item_data.quat_z;
      a_w    <= item_data.quat_w;
      a_wvx  <= item_data.quat_w * item_data.vec_x;
      a_uyvz <= item_data.quat_y * item_data.vec_z;
      a_uzvy <= item_data.quat_z * item_data.vec_y;
      a_wvy  <= item_data.quat_w * item_data.vec_y;
      a_uzvx <= item_data.quat_z * item_data.vec_x;
      a_uxvz <= item_data.quat_x * item_data.vec_z;
      a_wvz  <= item_data.quat_w * item_data.vec_z;
      a_uxvy <= item_data.quat_x * item_data.vec_y;
      a_uyvx <= item_data.quat_y * item_data.vec_x;
      a_uxvx <= item_data.quat_x * item_data.vec_x;
      a_uyvy <= item_data.quat_y * item_data.vec_y;
      a_uzvz <= item_data.quat_z * item_data.vec_z;
    end
  end

  // stage B: p = (px, py, pz, pw)
  logic signed [QW-1:0] b_ux, b_uy, b_uz, b_w;
  logic signed [PW-1:0] b_px, b_py, b_pz, b_pw;

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_ux <= a_ux;
      b_uy <= a_uy;
      b_uz <= a_uz;
      b_w  <= a_w;
      b_px <= PW'(a_wvx) - PW'(a_uyvz) + PW'(a_uzvy);
      b_py <= PW'(a_wvy) - PW'(a_uzvx) + PW'(a_uxvz);
      b_pz <= PW'(a_wvz) - PW'(a_uxvy) + PW'(a_uyvx);
      b_pw <= PW'(a_uxvx) + PW'(a_uyvy) + PW'(a_uzvz);
    end
  end

  // stage C: products of p * q, vector part; last term of each axis is
  // subtracted later, so no negated quaternion component is needed
  logic signed [NW-1:0] c_prod [3][4];

  always_ff @(posedge clk) begin
    if (c_en) begin
      c_prod[0][0] <= b_ux * b_pw;
      c_prod[0][1] <= b_w  * b_px;
      c_prod[0][2] <= b_uz * b_py;
      c_prod[0][3] <= b_uy * b_pz;
      c_prod[1][0] <= b_uy * b_pw;
      c_prod[1][1] <= b_w  * b_py;
      c_prod[1][2] <= b_ux * b_pz;
      c_prod[1][3] <= b_uz * b_px;
      c_prod[2][0] <= b_uz * b_pw;
      c_prod[2][1] <= b_w  * b_pz;
      c_prod[2][2] <= b_uy * b_px;
      c_prod[2][3] <= b_ux * b_py;
    end
  end

  // stage D: exact sum, round half up, drop the fraction
  logic signed [AW-1:0] d_round [3];
  logic signed [AW-1:0] d_round_next [3];
  logic signed [AW-1:0] d_sum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_sum[i] = AW'(c_prod[i][0]) + AW'(c_prod[i][1]) + AW'(c_prod[i][2])
               - AW'(c_prod[i][3]) + BIAS;
      d_round_next[i] = d_sum[i] >>> SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (d_en) begin
      for (int i = 0; i < 3; i++) begin
        d_round[i] <= d_round_next[i];
      end
    end
  end

  // stage E: clamp to the vector width into the output register
  logic signed [VW-1:0] e_comp [3];
  logic [2:0]           e_clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (d_round[i] > TOP) begin
        e_comp[i] = TOPV;
        e_clip[i] = 1'b1;
      end else if (d_round[i] < BOT) begin
        e_comp[i] = BOTV;
        e_clip[i] = 1'b1;
      end else begin
        e_comp[i] = d_round[i][VW-1:0];
        e_clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_en) begin
      result_data.out_x     <= e_comp[0];
      result_data.out_y     <= e_comp[1];
      result_data.out_z     <= e_comp[2];
      result_data.saturated <= |e_clip;
    end
  end

  // an empty result register means the pipe can always take a beat
  a_room : assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("input stalled with result register empty");

  // a clamped result has at least one component at a range limit
  a_sat : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.saturated |->
      (result_data.out_x == TOPV || result_data.out_x == BOTV ||
       result_data.out_y == TOPV || result_data.out_y == BOTV ||
       result_data.out_z == TOPV || result_data.out_z == BOTV))
    else $error("saturated set with no component at a limit");

  // a beat in the rounding stage is never dropped on its way out
  a_keep : assert property (@(posedge clk) disable iff (rst)
    d_valid && e_en |=> result_valid)
    else $error("beat lost between round and clamp stages");

  // a held middle stage keeps its beat
  a_hold : assert property (@(posedge clk) disable iff (rst)
    c_valid && !c_en |=> c_valid && $stable(c_prod[0][0]))
    else $error("stalled product stage changed");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotator bench
// Streams quaternion/vector beats through quaternion_vector_rotate and checks
// each result beat against a predictor that evaluates conj(q) * (v, 0) * q in
// exact 64-bit integer arithmetic. The predictor then rounds half up and
// clamps to the vector width. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int     CYCLE_LIMIT  = 500000;
  localparam int     SETTLE_TICKS = 12;   // pipe is five stages deep
  localparam int     RANDOM_BEATS = 1200;
  localparam int     REPORT_MAX   = 10;
  localparam int     PROD_SHIFT   = 2 * qvr_pkg::QUAT_FRAC_BITS;
  localparam longint HALF_LSB     = longint'(1) <<< (PROD_SHIFT - 1);
  localparam longint VEC_MAX      = (longint'(1) <<< (qvr_pkg::VEC_WIDTH - 1)) - 1;
  localparam longint VEC_MIN      = -VEC_MAX - 1;
  localparam int     Q_ONE        = 1 << qvr_pkg::QUAT_FRAC_BITS;   // 1.0 in Q1.F

  logic              clk;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  qvr_pkg::qvr_in_t  item_data    = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  qvr_pkg::qvr_out_t result_data;

  qvr_pkg::qvr_out_t rotated_q[$];      // predicted result beats, oldest first
  int       mismatches = 0;
  int       stall_left = 0;
  int       cycle_count;
  bit       idling     = 1'b0; // random gaps and stalls on both channels

  quaternion_vector_rotate u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: r = conj(q) * (v, 0) * q, vector part only.
  // p = conj(q) * (v, 0) carries F fraction bits; p * q carries 2F. The sum
  // is rounded half up (so -0.5 goes to 0) and clamped per component.
  // --------------------------------------------------------------------------
  function automatic qvr_pkg::qvr_out_t rotate_vector(input qvr_pkg::qvr_in_t beat);
    longint ux, uy, uz, w, vx, vy, vz;
    longint px, py, pz, pw, rounded;
    longint acc [3];
    logic signed [qvr_pkg::VEC_WIDTH-1:0] comp [3];
    logic clamped;
    int k;
    qvr_pkg::qvr_out_t res;
    ux = $signed(beat.quat_x);
    uy = $signed(beat.quat_y);
    uz = $signed(beat.quat_z);
    w  = $signed(beat.quat_w);
    vx = $signed(beat.vec_x);
    vy = $signed(beat.vec_y);
    vz = $signed(beat.vec_z);
    // first product: w*v - u x v, scalar u.v
    px = w * vx - (uy * vz - uz * vy);
    py = w * vy - (uz * vx - ux * vz);
    pz = w * vz - (ux * vy - uy * vx);
    pw = ux * vx + uy * vy + uz * vz;
    // second product, vector part: u*pw + w*pv + pv x u
    acc[0] = ux * pw + w * px + uz * py - uy * pz;
    acc[1] = uy * pw + w * py + ux * pz - uz * px;
    acc[2] = uz * pw + w * pz + uy * px - ux * py;
    clamped = 1'b0;
    for (k = 0; k < 3; k++) begin
      rounded = (acc[k] + HALF_LSB) >>> PROD_SHIFT;
      if (rounded > VEC_MAX) begin
        rounded = VEC_MAX;
        clamped = 1'b1;
      end else if (rounded < VEC_MIN) begin
        rounded = VEC_MIN;
        clamped = 1'b1;
      end
      comp[k] = rounded[qvr_pkg::VEC_WIDTH-1:0];
    end
    res.out_x     = comp[0];
    res.out_y     = comp[1];
    res.out_z     = comp[2];
    res.saturated = clamped;
    return res;
  endfunction

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // uniform in [-lim, lim]
  function automatic int span(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic qvr_pkg::qvr_in_t make_beat(input int qx, qy, qz, qw, vx, vy, vz);
    qvr_pkg::qvr_in_t b;
    b.quat_x = qvr_pkg::QUAT_WIDTH'(qx);
    b.quat_y = qvr_pkg::QUAT_WIDTH'(qy);
    b.quat_z = qvr_pkg::QUAT_WIDTH'(qz);
    b.quat_w = qvr_pkg::QUAT_WIDTH'(qw);
    b.vec_x  = qvr_pkg::VEC_WIDTH'(vx);
    b.vec_y  = qvr_pkg::VEC_WIDTH'(vy);
    b.vec_z  = qvr_pkg::VEC_WIDTH'(vz);
    return b;
  endfunction

  // Mix of true rotations, shrinking quaternions, raw random bits and
  // single-axis quaternions, so both the clamp and the in-range paths are hit.
  function automatic qvr_pkg::qvr_in_t random_beat();
    qvr_pkg::qvr_in_t b;
    int pick;
    real qx, qy, qz, qw, mag;
    pick = $urandom_range(0, 99);
    b = make_beat(0, 0, 0, 0, int'($urandom), int'($urandom), int'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      b.vec_x = qvr_pkg::VEC_WIDTH'(span(1000));
      b.vec_y = qvr_pkg::VEC_WIDTH'(span(1000));
      b.vec_z = qvr_pkg::VEC_WIDTH'(span(1000));
    end
    if (pick < 45) begin
      // unit quaternion: normalise a random direction to 1.0
      qx  = span(Q_ONE);
      qy  = span(Q_ONE);
      qz  = span(Q_ONE);
      qw  = span(Q_ONE);
      mag = $sqrt(qx * qx + qy * qy + qz * qz + qw * qw);
      if (mag < 1.0) begin
        qw  = 1.0;
        mag = 1.0;
      end
      b.quat_x = qvr_pkg::QUAT_WIDTH'($rtoi(qx * Q_ONE / mag));
      b.quat_y = qvr_pkg::QUAT_WIDTH'($rtoi(qy * Q_ONE / mag));
      b.quat_z = qvr_pkg::QUAT_WIDTH'($rtoi(qz * Q_ONE / mag));
      b.quat_w = qvr_pkg::QUAT_WIDTH'($rtoi(qw * Q_ONE / mag));
    end else if (pick < 70) begin
      b.quat_x = qvr_pkg::QUAT_WIDTH'(span(Q_ONE / 2));
      b.quat_y = qvr_pkg::QUAT_WIDTH'(span(Q_ONE / 2));
      b.quat_z = qvr_pkg::QUAT_WIDTH'(span(Q_ONE / 2));
      b.quat_w = qvr_pkg::QUAT_WIDTH'(span(Q_ONE / 2));
    end else if (pick < 85) begin
      b.quat_x = qvr_pkg::QUAT_WIDTH'($urandom);
      b.quat_y = qvr_pkg::QUAT_WIDTH'($urandom);
      b.quat_z = qvr_pkg::QUAT_WIDTH'($urandom);
      b.quat_w = qvr_pkg::QUAT_WIDTH'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: b.quat_x = qvr_pkg::QUAT_WIDTH'($urandom);
        1: b.quat_y = qvr_pkg::QUAT_WIDTH'($urandom);
        2: b.quat_z = qvr_pkg::QUAT_WIDTH'($urandom);
        default: b.quat_w = qvr_pkg::QUAT_WIDTH'($urandom);
      endcase
    end
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. valid stays high across back-to-back beats; it only drops for a
  // gap, and the data bus carries junk while it is low.
  // --------------------------------------------------------------------------
  task automatic send_vector(input qvr_pkg::qvr_in_t beat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      item_data  <= random_beat();
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_data  <= beat;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    rotated_q.push_back(rotate_vector(beat));
  endtask

  // drop valid and let every outstanding result beat come back
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: compare each accepted beat with the oldest prediction, and
  // drive result_stall in random bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_side
    qvr_pkg::qvr_out_t want;
    int hold;
    if (!rst && result_valid && !result_stall) begin
      if (rotated_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result beat x=%0d y=%0d z=%0d sat=%0b with none pending",
                   $realtime, result_data.out_x, result_data.out_y,
                   result_data.out_z, result_data.saturated);
      end else begin
        want = rotated_q.pop_front();
        if (result_data.out_x !== want.out_x || result_data.out_y !== want.out_y ||
            result_data.out_z !== want.out_z ||
            result_data.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: mismatch exp x=%0d y=%0d z=%0d sat=%0b got x=%0d y=%0d z=%0d sat=%0b",
                     $realtime, want.out_x, want.out_y, want.out_z, want.saturated,
                     result_data.out_x, result_data.out_y, result_data.out_z,
                     result_data.saturated);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      hold = pick_gap();
      stall_left = (hold > 0) ? hold - 1 : 0;
      result_stall <= (hold > 0);
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // identity, quarter and half turns, zero quaternion, full-scale vectors
  task automatic test_rotations();
    idling = 1'b0;
    send_vector(make_beat(0, 0, 0, Q_ONE, 32767, -32768, 0));
    send_vector(make_beat(0, 0, 0, Q_ONE, -1, 1, 12345));
    send_vector(make_beat(0, 0, 11585, 11585, 1000, 0, 0));      // 90 deg about z
    send_vector(make_beat(Q_ONE, 0, 0, 0, 100, 200, 300));       // 180 deg about x
    // half turn about -y flips -32768 to +32768, which must clamp
    send_vector(make_beat(0, -Q_ONE, 0, 0, -32768, 32767, -32768));
    send_vector(make_beat(0, 0, 0, 0, 32767, 32767, 32767));
  endtask

  // q = 0.5 scales v by 1/4: exact halves and quarters hit the rounding
  task automatic test_rounding();
    idling = 1'b1;
    send_vector(make_beat(0, 0, 0, Q_ONE / 2, 2, -2, -6));   // 0.5, -0.5, -1.5
    send_vector(make_beat(0, 0, 0, Q_ONE / 2, 1, -1, 3));
    send_vector(make_beat(0, 0, 0, Q_ONE / 2, 32767, -32768, 5));
  endtask

  // non-unit quaternions scale by |q|^2, including the most negative codes
  task automatic test_saturation();
    idling = 1'b1;
    send_vector(make_beat(0, 0, 0, 32767, 32767, -32768, 1));
    send_vector(make_beat(0, 0, 0, -32768, 16384, -16384, 0));
    send_vector(make_beat(32767, 32767, 32767, 32767, -32768, -32768, -32768));
    send_vector(make_beat(-32768, -32768, -32768, -32768, 32767, 0, -32768));
    send_vector(make_beat(0, 0, 0, 23170, 20000, 100, -100)); // only x clamps
    send_vector(make_beat(-32768, 0, 0, 0, 1, 1, 1));
  endtask

  // back to back with no idling, pause for a full drain, then resume idling
  task automatic test_drain_pause();
    int i;
    idling = 1'b0;
    for (i = 0; i < 40; i++) send_vector(random_beat());
    wait_drained();
    idling = 1'b1;
    for (i = 0; i < 40; i++) send_vector(random_beat());
    wait_drained();
  endtask

  // long random stream; idling switches on and off in stretches
  task automatic test_random_stream();
    int i;
    for (i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 150 == 0) idling = ($urandom_range(0, 3) != 0);
      if (i == RANDOM_BEATS / 2) wait_drained();
      send_vector(random_beat());
    end
  endtask

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : run
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_rotations();
    test_rounding();
    test_saturation();
    test_drain_pause();
    test_random_stream();
    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
